### rtl/hbdm_pkg.sv
`default_nettype none

package hbdm_pkg;

    localparam logic [6:0] MAX_VALUE = 7'd127;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_REAPPLY = 2'd1,
        CMD_ON      = 2'd2,
        CMD_OFF     = 2'd3
    } hbdm_cmd_t;

    typedef enum logic [1:0] {
        PINS_OFF = 2'd0,
        PINS_POS = 2'd1,
        PINS_NEG = 2'd2
    } hbdm_pins_t;

    localparam logic [1:0] CFG_MIDPOINT   = 2'd0;
    localparam logic [1:0] CFG_RESOLUTION = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } hbdm_state_t;

    // Where a value lies against the midpoint.
    typedef struct packed {
        logic same;
        logic ends;
        logic below;
    } hbdm_class_t;

    function automatic hbdm_class_t hbdm_classify(input logic [6:0] v, input logic [6:0] m);
        hbdm_class_t c;
        c.same  = (v == m);
        c.ends  = (v != m) && ((v == 7'd0) || (v == MAX_VALUE));
        c.below = (v < m);
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/hbridge_bipolar_drive_mapper.sv
// H-bridge drive mapper: turns a 7-bit control value, placed around a
// programmable midpoint, into a PWM duty and a pair of bridge pins.
// Input channel: in_valid/in_stall with command and drive_value. An item is
// taken when in_valid is high and in_stall is low.
// Output channel: out_valid/out_stall with duty_valid, duty and bridge_pins,
// exactly one result item for each input item.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; index 0 is
// the midpoint, index 1 the PWM resolution, other indexes are ignored.
// cfg_ready is always high and a write takes effect in the same edge.
// Commands that need a scaled duty pass through 7 multiply steps and 8 divide
// steps before the output step; all other items go straight to the output
// step. The shift-add multiplier and the restoring divider each work one bit
// per cycle.
// A new item is accepted in the cycle after the previous one reaches the
// output register, even while that result waits under out_stall; if the
// receiver keeps stalling, the next result waits in the block.
// Reset clears the midpoint, sets the resolution to 127, turns the bridge
// off and empties the output register.
`default_nettype none

module hbridge_bipolar_drive_mapper
    import hbdm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] drive_value,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            duty_valid,
    output logic [7:0]      duty,
    output logic [1:0]      bridge_pins,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data
);

    hbdm_state_t state_reg, state_next;
    logic [6:0]  midpoint_reg, midpoint_next;
    logic [7:0]  resolution_reg, resolution_next;
    logic [6:0]  stored_reg, stored_next;
    logic        last_dir_reg, last_dir_next;
    hbdm_pins_t  pins_reg, pins_next;

    logic [14:0] acc_reg, acc_next;
    logic [6:0]  mplier_reg, mplier_next;
    logic [6:0]  divisor_reg, divisor_next;
    logic [2:0]  cnt_reg, cnt_next;

    logic        res_valid_reg, res_valid_next;
    logic [7:0]  res_duty_reg, res_duty_next;
    hbdm_pins_t  res_pins_reg, res_pins_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_dv_reg, out_dv_next;
    logic [7:0]  out_duty_reg, out_duty_next;
    hbdm_pins_t  out_pins_reg, out_pins_next;

    logic [6:0]  v_clamp;
    logic [6:0]  v_sel;
    hbdm_class_t cls_item;
    hbdm_class_t cls_cfg;
    logic [7:0]  trial;
    logic        trial_ge;
    logic [7:0]  trial_rem;
    hbdm_cmd_t   cmd;

    assign cmd       = hbdm_cmd_t'(command);
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign duty_valid  = out_dv_reg;
    assign duty        = out_duty_reg;
    assign bridge_pins = out_pins_reg;

    assign v_clamp  = drive_value[7] ? MAX_VALUE : drive_value[6:0];
    assign v_sel    = (cmd == CMD_SET) ? v_clamp : stored_reg;
    assign cls_item = hbdm_classify(v_sel, midpoint_reg);
    assign cls_cfg  = hbdm_classify(stored_reg, cfg_data[6:0]);

    // One restoring divide step: the partial remainder sits in acc[14:8] and
    // the dividend bits still to come are shifted out of acc[7:0].
    assign trial     = {acc_reg[14:8], acc_reg[7]};
    assign trial_ge  = (trial >= {1'b0, divisor_reg});
    assign trial_rem = trial_ge ? (trial - {1'b0, divisor_reg}) : trial;

    always_comb
    begin
        state_next      = state_reg;
        midpoint_next   = midpoint_reg;
        resolution_next = resolution_reg;
        stored_next     = stored_reg;
        last_dir_next   = last_dir_reg;
        pins_next       = pins_reg;
        acc_next        = acc_reg;
        mplier_next     = mplier_reg;
        divisor_next    = divisor_reg;
        cnt_next        = cnt_reg;
        res_valid_next  = res_valid_reg;
        res_duty_next   = res_duty_reg;
        res_pins_next   = res_pins_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_dv_next     = out_dv_reg;
        out_duty_next   = out_duty_reg;
        out_pins_next   = out_pins_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_valid_next = 1'b0;
                    res_duty_next  = 8'd0;
                    state_next     = ST_FIN;
                    case (cmd)
                        CMD_SET, CMD_REAPPLY:
                        begin
                            res_valid_next = 1'b1;
                            stored_next    = v_sel;
                            if (cls_item.same)
                            begin
                                res_duty_next = 8'd0;
                            end
                            else if (cls_item.ends)
                            begin
                                pins_next     = PINS_OFF;
                                res_duty_next = resolution_reg + 8'd1;
                            end
                            else
                            begin
                                last_dir_next = !cls_item.below;
                                pins_next     = cls_item.below ? PINS_POS : PINS_NEG;
                                mplier_next   = cls_item.below ? (midpoint_reg - v_sel)
                                                               : (v_sel - midpoint_reg);
                                divisor_next  = cls_item.below ? midpoint_reg
                                                               : (MAX_VALUE - midpoint_reg);
                                acc_next      = 15'd0;
                                cnt_next      = 3'd6;
                                state_next    = ST_MUL;
                            end
                        end
                        CMD_ON:
                        begin
                            pins_next = last_dir_reg ? PINS_NEG : PINS_POS;
                        end
                        default:
                        begin
                            pins_next = PINS_OFF;
                        end
                    endcase
                    res_pins_next = pins_next;
                end
            end
            ST_MUL:
            begin
                acc_next    = {acc_reg[13:0], 1'b0}
                            + (mplier_reg[6] ? {7'd0, resolution_reg} : 15'd0);
                mplier_next = {mplier_reg[5:0], 1'b0};
                if (cnt_reg == 3'd0)
                begin
                    cnt_next   = 3'd7;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ST_DIV:
            begin
                acc_next = {trial_rem[6:0], acc_reg[6:0], trial_ge};
                if (cnt_reg == 3'd0)
                begin
                    res_duty_next = {acc_reg[6:0], trial_ge};
                    state_next    = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_dv_next    = res_valid_reg;
                    out_duty_next  = res_duty_reg;
                    out_pins_next  = res_pins_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A midpoint write maps the stored value again without a result item.
        if (cfg_valid)
        begin
            if (cfg_index == CFG_MIDPOINT)
            begin
                midpoint_next = cfg_data[6:0];
                if (cls_cfg.ends)
                begin
                    pins_next = PINS_OFF;
                end
                else if (!cls_cfg.same)
                begin
                    last_dir_next = !cls_cfg.below;
                    pins_next     = cls_cfg.below ? PINS_POS : PINS_NEG;
                end
            end
            else if (cfg_index == CFG_RESOLUTION)
            begin
                resolution_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            midpoint_reg   <= 7'd0;
            resolution_reg <= 8'd127;
            stored_reg     <= 7'd0;
            last_dir_reg   <= 1'b0;
            pins_reg       <= PINS_OFF;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            midpoint_reg   <= midpoint_next;
            resolution_reg <= resolution_next;
            stored_reg     <= stored_next;
            last_dir_reg   <= last_dir_next;
            pins_reg       <= pins_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg        <= acc_next;
        mplier_reg     <= mplier_next;
        divisor_reg    <= divisor_next;
        cnt_reg        <= cnt_next;
        res_valid_reg  <= res_valid_next;
        res_duty_reg   <= res_duty_next;
        res_pins_reg   <= res_pins_next;
        out_dv_reg     <= out_dv_next;
        out_duty_reg   <= out_duty_next;
        out_pins_reg   <= out_pins_next;
    end

`ifndef NO_ASSERTIONS
    // The last divide step always hands its quotient to the output stage.
    a_div_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && (cnt_reg == 3'd0) |=> (state_reg == ST_FIN))
        else $error("divider did not finish into the output stage");

    // Commands that only move the pins never start the arithmetic.
    a_pin_cmd_short: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && ((cmd == CMD_ON) || (cmd == CMD_OFF))
        |=> (state_reg == ST_FIN))
        else $error("pin command entered the arithmetic path");

    // A result without a new duty carries a zero duty.
    a_no_duty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !duty_valid |-> (duty == 8'd0))
        else $error("duty nonzero on a result without a duty update");

    // The bridge is never driven in both directions at once.
    a_pins_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (bridge_pins != 2'b11))
        else $error("both bridge pins driven");
`endif

endmodule

`default_nettype wire

### test/hbdm_checker.sv
`default_nettype none

module hbdm_checker
    import hbdm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_stall,
    input  wire logic [1:0] command,
    input  wire logic [7:0] drive_value,
    input  wire logic       out_valid,
    input  wire logic       out_stall,
    input  wire logic       duty_valid,
    input  wire logic [7:0] duty,
    input  wire logic [1:0] bridge_pins,
    input  wire logic       cfg_valid,
    input  wire logic       cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    output int              mismatches,
    output int              pending,
    output int              results_seen
);

    typedef struct packed {
        logic       duty_valid;
        logic [7:0] duty;
        logic [1:0] pins;
    } drive_result_t;

    drive_result_t drive_q[$];

    // Shadow copy of the registers and the bridge state.
    logic [6:0] midpoint_r   = '0;
    logic [7:0] resolution_r = 8'd127;
    logic [6:0] stored_r     = '0;
    logic       last_neg_r   = 1'b0;
    hbdm_pins_t pins_r       = PINS_OFF;

    int err_count  = 0;
    int pend_count = 0;
    int seen_count = 0;

    assign mismatches   = err_count;
    assign pending      = pend_count;
    assign results_seen = seen_count;

    // Maps a clamped value against the midpoint, updating the direction state.
    function automatic logic [7:0] map_drive(input logic [6:0] v);
        int unsigned m;
        int unsigned r;
        int unsigned x;
        int unsigned top;
        m   = 32'(midpoint_r);
        r   = 32'(resolution_r);
        x   = 32'(v);
        top = 32'(MAX_VALUE);
        stored_r = v;
        if (x == m)
        begin
            return 8'd0;
        end
        if (x == 0 || x == top)
        begin
            pins_r = PINS_OFF;
            return 8'(r + 1);
        end
        if (x < m)
        begin
            last_neg_r = 1'b0;
            pins_r = PINS_POS;
            return 8'((r * (m - x)) / m);
        end
        last_neg_r = 1'b1;
        pins_r = PINS_NEG;
        return 8'((r * (x - m)) / (top - m));
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        err_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track_drive
        drive_result_t want;
        logic [6:0]    v;
        if (!rst_n)
        begin
            drive_q.delete();
            midpoint_r   = '0;
            resolution_r = 8'd127;
            stored_r     = '0;
            last_neg_r   = 1'b0;
            pins_r       = PINS_OFF;
            pend_count   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                begin
                    report($sformatf("result duty_valid=%0d duty=%0d pins=%0d unexpected",
                                     duty_valid, duty, bridge_pins));
                end
                else
                begin
                    want = drive_q.pop_front();
                    seen_count++;
                    if (duty_valid !== want.duty_valid)
                        report($sformatf("duty_valid got %0d expected %0d",
                                         duty_valid, want.duty_valid));
                    if (duty !== want.duty)
                        report($sformatf("duty got %0d expected %0d", duty, want.duty));
                    if (bridge_pins !== want.pins)
                        report($sformatf("bridge_pins got %0d expected %0d",
                                         bridge_pins, want.pins));
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_MIDPOINT)
                begin
                    // A new midpoint remaps the stored value without a result.
                    midpoint_r = cfg_data[6:0];
                    void'(map_drive(stored_r));
                end
                else if (cfg_index == CFG_RESOLUTION)
                begin
                    resolution_r = cfg_data;
                end
            end

            if (in_valid && !in_stall)
            begin
                v = (drive_value > {1'b0, MAX_VALUE}) ? MAX_VALUE : drive_value[6:0];
                want.duty_valid = 1'b0;
                want.duty = 8'd0;
                case (hbdm_cmd_t'(command))
                    CMD_SET:
                    begin
                        want.duty = map_drive(v);
                        want.duty_valid = 1'b1;
                    end
                    CMD_REAPPLY:
                    begin
                        want.duty = map_drive(stored_r);
                        want.duty_valid = 1'b1;
                    end
                    CMD_ON:
                    begin
                        pins_r = last_neg_r ? PINS_NEG : PINS_POS;
                    end
                    default:
                    begin
                        pins_r = PINS_OFF;
                    end
                endcase
                want.pins = pins_r;
                drive_q.push_back(want);
            end
            pend_count = drive_q.size();
        end
    end

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb
    import hbdm_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASES         = 12;
    localparam int CHUNKS         = 3;
    localparam int CHUNK_ITEMS    = 50;

    // Indexes that the block must ignore.
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int MODE_NONE     = 0;
    localparam int MODE_SENDER   = 1;
    localparam int MODE_RECEIVER = 2;
    localparam int MODE_BOTH     = 3;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic [1:0] command     = CMD_SET;
    logic [7:0] drive_value = 8'd0;
    logic       out_stall   = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic [1:0] cfg_index   = CFG_MIDPOINT;
    logic [7:0] cfg_data    = 8'd0;

    logic       in_stall;
    logic       out_valid;
    logic       duty_valid;
    logic [7:0] duty;
    logic [1:0] bridge_pins;
    logic       cfg_ready;

    int mismatches;
    int pending;
    int results_seen;

    int         items_sent   = 0;
    int         reg_writes   = 0;
    int         idle_mode    = MODE_NONE;
    int         quiet_cycles = 0;
    logic       hold_req     = 1'b0;
    logic       hold_done    = 1'b0;
    logic [6:0] cur_mid      = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    hbridge_bipolar_drive_mapper dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .drive_value (drive_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .duty_valid  (duty_valid),
        .duty        (duty),
        .bridge_pins (bridge_pins),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    hbdm_checker drive_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .drive_value  (drive_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .duty_valid   (duty_valid),
        .duty         (duty),
        .bridge_pins  (bridge_pins),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen)
    );

    function automatic int sender_pct();
        if (idle_mode == MODE_SENDER)
            return 76;
        if (idle_mode == MODE_BOTH)
            return 19;
        return 0;
    endfunction

    function automatic int receiver_pct();
        if (idle_mode == MODE_RECEIVER)
            return 76;
        if (idle_mode == MODE_BOTH)
            return 19;
        return 0;
    endfunction

    function automatic logic [7:0] pick_value();
        int         sel;
        logic [7:0] r;
        sel = $urandom_range(99);
        if (sel < 12)
        begin
            r = 8'($urandom_range(255, 128));
        end
        else if (sel < 24)
        begin
            case ($urandom_range(4))
                0: r = 8'd0;
                1: r = {1'b0, MAX_VALUE};
                2: r = {1'b0, cur_mid};
                3: r = {1'b0, cur_mid} + 8'd1;
                default: r = {1'b0, cur_mid} - 8'd1;
            endcase
        end
        else
        begin
            r = 8'($urandom_range(127));
        end
        return r;
    endfunction

    function automatic hbdm_cmd_t pick_command();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50)
            return CMD_SET;
        if (sel < 70)
            return CMD_REAPPLY;
        if (sel < 85)
            return CMD_ON;
        return CMD_OFF;
    endfunction

    // The receiver stalls at random, except for one long hold that fills the block.
    initial
    begin : receiver_side
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < receiver_pct());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no channel moved for %0d cycles", WATCHDOG_LIMIT);
                $display("hbridge_bipolar_drive_mapper verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Leaves valid high after acceptance so back-to-back items need no toggle.
    task automatic send_item(input hbdm_cmd_t op, input logic [7:0] value);
        logic taken;
        while ($urandom_range(99) < sender_pct())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= op;
        drive_value <= value;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end while (!taken);
        items_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
        begin
            @(negedge clk);
        end while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A midpoint write remaps the stored value at the writing edge; a short
    // pause follows every write before anything else moves.
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        logic taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end while (!taken);
        cfg_valid <= 1'b0;
        if (idx == CFG_MIDPOINT)
            cur_mid = data[6:0];
        reg_writes++;
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] mid_pick;
        logic [7:0] res_pick;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: midpoint 0, so any nonzero value below 127 is negative.
        send_item(CMD_SET, 8'd5);
        settle();

        write_reg(CFG_MIDPOINT, 8'd64);
        write_reg(CFG_RESOLUTION, 8'd200);
        send_item(CMD_SET, 8'd64);
        send_item(CMD_SET, 8'd0);
        send_item(CMD_SET, 8'd127);
        send_item(CMD_SET, 8'd255);
        send_item(CMD_SET, 8'd200);
        send_item(CMD_SET, 8'd1);
        send_item(CMD_SET, 8'd63);
        send_item(CMD_SET, 8'd65);
        send_item(CMD_SET, 8'd126);
        send_item(CMD_REAPPLY, 8'd0);
        send_item(CMD_OFF, 8'd0);
        send_item(CMD_ON, 8'd0);
        send_item(CMD_REAPPLY, 8'd17);
        send_item(CMD_SET, 8'd30);
        settle();

        // Moving the midpoint under the stored value flips the direction.
        write_reg(CFG_MIDPOINT, 8'd20);
        send_item(CMD_OFF, 8'd0);
        send_item(CMD_ON, 8'd0);
        send_item(CMD_REAPPLY, 8'd0);
        settle();

        // Resolution 255 makes the off duty wrap to zero.
        write_reg(CFG_MIDPOINT, 8'd0);
        write_reg(CFG_RESOLUTION, 8'd255);
        send_item(CMD_SET, 8'd0);
        send_item(CMD_SET, 8'd1);
        send_item(CMD_SET, 8'd127);
        settle();

        write_reg(CFG_MIDPOINT, 8'd127);
        write_reg(CFG_RESOLUTION, 8'd0);
        send_item(CMD_SET, 8'd127);
        send_item(CMD_SET, 8'd126);
        send_item(CMD_SET, 8'd0);
        settle();
        write_reg(CFG_SPARE_2, 8'hA5);
        write_reg(CFG_SPARE_3, 8'h5A);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            idle_mode = p % 4;
            case (p)
                0: res_pick = 8'd255;
                1: res_pick = 8'd0;
                2: res_pick = 8'd1;
                3: res_pick = 8'd127;
                default: res_pick = 8'($urandom_range(255));
            endcase
            write_reg(CFG_RESOLUTION, res_pick);
            if (p % 3 == 0)
                write_reg(($urandom_range(1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                          8'($urandom_range(255)));
            if (p == 4)
                hold_req = 1'b1;
            for (int c = 0; c < CHUNKS; c++)
            begin
                if (c > 0)
                    settle();
                case ($urandom_range(9))
                    0: mid_pick = 8'd0;
                    1: mid_pick = 8'd127;
                    2: mid_pick = 8'd1;
                    3: mid_pick = 8'd126;
                    default: mid_pick = 8'($urandom_range(127));
                endcase
                // The top bit of the midpoint data is ignored but still toggled.
                mid_pick[7] = 1'($urandom_range(1));
                write_reg(CFG_MIDPOINT, mid_pick);
                for (int i = 0; i < CHUNK_ITEMS; i++)
                    send_item(pick_command(), pick_value());
            end
        end
        settle();

        $display("Covered %0d items and %0d results with %0d register writes, midpoint and",
                 items_sent, results_seen, reg_writes);
        $display("resolution at both ends, four idle patterns and a %0d-cycle output hold.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
        begin
            $display("hbridge_bipolar_drive_mapper verification clean");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches, pending);
            $display("hbridge_bipolar_drive_mapper verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
